[rtl/csa_pkg.sv]
// ----------------------------------------------------------------------------
// csa_pkg: shared types and constants of the connection slot allocator
// Table sizes, opcode and status codes, queue and memory entry layouts.
// ----------------------------------------------------------------------------
`default_nettype none

package csa_pkg;

  localparam int SLOTS    = 64;
  localparam int FD_SPACE = 1024;
  localparam int SLOT_W   = 6;
  localparam int FD_W     = 10;
  localparam int EV_W     = 16;
  localparam int CNT_W    = 7;

  // raw opcode values on the request channel
  localparam logic [2:0] OPC_RELEASE = 3'd4;

  // result status codes
  localparam logic [1:0] ST_DONE = 2'd0;
  localparam logic [1:0] ST_NONE = 2'd1;
  localparam logic [1:0] ST_FULL = 2'd2;
  localparam logic [1:0] ST_BAD  = 2'd3;

  typedef enum logic [2:0] {
    OP_ACQUIRE = 3'd0,
    OP_RECYCLE = 3'd1,
    OP_PARK    = 3'd2,
    OP_RESUME  = 3'd3,
    OP_RELEASE = 3'd4,
    OP_BAD     = 3'd5
  } op_t;

  typedef struct packed {
    op_t               op;
    logic [FD_W-1:0]   fd;
    logic [EV_W-1:0]   ev;
    logic [SLOT_W-1:0] sidx;
  } cmd_t;

  typedef struct packed {
    logic valid;
    cmd_t cmd;
  } cmd_req_t;

  // per-descriptor entry: owner slot and parked events
  typedef struct packed {
    logic              ov;
    logic [SLOT_W-1:0] oi;
    logic              pv;
    logic [EV_W-1:0]   pe;
  } map_ent_t;

  // per-slot entry: owner descriptor and armed events
  typedef struct packed {
    logic [FD_W-1:0] fd;
    logic [EV_W-1:0] ev;
  } slot_ent_t;

endpackage

`default_nettype wire

[rtl/csa_in_if.sv]
// ----------------------------------------------------------------------------
// csa_in_if: request channel
// Valid/ready handshake carrying one allocator request.
// ----------------------------------------------------------------------------
`default_nettype none

interface csa_in_if;
  logic        valid;
  logic        ready;
  logic [2:0]  opcode;
  logic [9:0]  descriptor;
  logic [15:0] event_mask;
  logic [5:0]  slot_index;

  modport source (output valid, opcode, descriptor, event_mask, slot_index, input ready);
  modport sink   (input valid, opcode, descriptor, event_mask, slot_index, output ready);
endinterface

`default_nettype wire

[rtl/csa_out_if.sv]
// ----------------------------------------------------------------------------
// csa_out_if: result channel
// Valid/ready handshake carrying one allocator result.
// ----------------------------------------------------------------------------
`default_nettype none

interface csa_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [5:0]  slot_out;
  logic [15:0] events_out;

  modport source (output valid, status, slot_out, events_out, input ready);
  modport sink   (input valid, status, slot_out, events_out, output ready);
endinterface

`default_nettype wire

[rtl/connection_slot_allocator_unit.sv]
// Sequence: an accepted request reads the tables in S_A, and its result is registered there for acquire, resume,
// release and bad opcodes; recycle and park, when they proceed, go on through S_B (two dependent memory reads).
// Flow: one request at a time; the back end takes
// the next request only after the previous result has been accepted.
// Reset: synchronous active-low; afterwards the descriptor map is swept clear
// entry by entry, during which requests queue but are not executed.
// ----------------------------------------------------------------------------
// connection_slot_allocator_unit: connection slot allocator top level
// Front end decodes and queues requests; back end runs them against the tables.
// ----------------------------------------------------------------------------
`default_nettype none

module connection_slot_allocator_unit (
  input  wire        clk,
  input  wire        rst_n,
  csa_in_if.sink     in_ch,
  csa_out_if.source  out_ch
);

  csa_pkg::cmd_req_t pop_req;
  logic              pop_ready;

  // intake and classification
  csa_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .pop_req   (pop_req),
    .pop_ready (pop_ready)
  );

  // execution
  csa_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .pop_req   (pop_req),
    .pop_ready (pop_ready),
    .out_ch    (out_ch)
  );

endmodule

`default_nettype wire

[rtl/csa_front.sv]
// ----------------------------------------------------------------------------
// csa_front: request intake
// Decodes the opcode and holds requests in a two-entry queue for the back end.
// ----------------------------------------------------------------------------
`default_nettype none

module csa_front (
  input  wire               clk,
  input  wire               rst_n,
  csa_in_if.sink            in_ch,
  output csa_pkg::cmd_req_t pop_req,
  input  wire               pop_ready
);

  csa_pkg::cmd_t q_r [2];
  logic          wp_r, wp_nxt;
  logic          rp_r, rp_nxt;
  logic [1:0]    cnt_r, cnt_nxt;
  csa_pkg::cmd_t dec;
  logic          push, pop;

  // opcode classification
  always_comb begin
    dec.fd   = in_ch.descriptor;
    dec.ev   = in_ch.event_mask;
    dec.sidx = in_ch.slot_index;
    if (in_ch.opcode <= csa_pkg::OPC_RELEASE) begin
      dec.op = csa_pkg::op_t'(in_ch.opcode);
    end else begin
      dec.op = csa_pkg::OP_BAD;
    end
  end

  assign in_ch.ready = (cnt_r != 2'd2);
  assign push        = in_ch.valid && in_ch.ready;
  assign pop_req     = '{valid: (cnt_r != 2'd0), cmd: q_r[rp_r]};
  assign pop         = pop_req.valid && pop_ready;

  // queue pointers
  always_comb begin
    wp_nxt  = push ? ~wp_r : wp_r;
    rp_nxt  = pop ? ~rp_r : rp_r;
    cnt_nxt = cnt_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  // queue storage
  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wp_r] <= dec;
    end
  end

endmodule

`default_nettype wire

[rtl/csa_back.sv]
// ----------------------------------------------------------------------------
// csa_back: request execution
// Descriptor map, slot table and free stack; one request at a time.
// ----------------------------------------------------------------------------
`default_nettype none

module csa_back (
  input  wire                    clk,
  input  wire                    rst_n,
  input  wire csa_pkg::cmd_req_t pop_req,
  output logic                   pop_ready,
  csa_out_if.source              out_ch
);

  localparam int SW = csa_pkg::SLOT_W;
  localparam int FW = csa_pkg::FD_W;
  localparam int EW = csa_pkg::EV_W;
  localparam int CW = csa_pkg::CNT_W;

  typedef enum logic [3:0] {
    S_CLR  = 4'b0001,
    S_IDLE = 4'b0010,
    S_A    = 4'b0100,
    S_B    = 4'b1000
  } state_t;

  state_t                 state_r, state_nxt;
  csa_pkg::cmd_t          item_r, item_nxt;
  logic [CW-1:0]          hw_r, hw_nxt;
  logic [CW-1:0]          fc_r, fc_nxt;
  logic [csa_pkg::SLOTS-1:0] live_r, live_nxt;
  logic [FW-1:0]          clr_r, clr_nxt;
  logic                   ov_r, ov_nxt;
  logic [1:0]             st_r, st_nxt;
  logic [SW-1:0]          so_r, so_nxt;
  logic [EW-1:0]          eo_r, eo_nxt;

  // memories
  csa_pkg::map_ent_t  map_mem [csa_pkg::FD_SPACE];
  csa_pkg::slot_ent_t slot_mem [csa_pkg::SLOTS];
  logic [SW-1:0]      stk_mem [csa_pkg::SLOTS];
  csa_pkg::map_ent_t  map_rd_r;
  csa_pkg::slot_ent_t slot_rd_r;
  logic [SW-1:0]      stk_rd_r;

  logic               map_we, slot_we, stk_we;
  logic [FW-1:0]      map_wa, map_ra;
  csa_pkg::map_ent_t  map_wd;
  logic [SW-1:0]      slot_wa, slot_ra;
  csa_pkg::slot_ent_t slot_wd;
  logic [SW-1:0]      stk_wa, stk_ra, stk_wd;

  logic               take_ok;
  logic [SW-1:0]      take_idx;
  csa_pkg::map_ent_t  ent;

  assign ent      = map_rd_r;
  assign take_ok  = (fc_r != '0) || (hw_r < CW'(csa_pkg::SLOTS));
  assign take_idx = (fc_r != '0) ? stk_rd_r : hw_r[SW-1:0];

  assign out_ch.valid      = ov_r;
  assign out_ch.status     = st_r;
  assign out_ch.slot_out   = so_r;
  assign out_ch.events_out = eo_r;

  // request sequencer
  always_comb begin
    state_nxt = state_r;
    item_nxt  = item_r;
    hw_nxt    = hw_r;
    fc_nxt    = fc_r;
    live_nxt  = live_r;
    clr_nxt   = clr_r;
    ov_nxt    = ov_r && !out_ch.ready;
    st_nxt    = st_r;
    so_nxt    = so_r;
    eo_nxt    = eo_r;
    pop_ready = 1'b0;
    map_we    = 1'b0;
    map_wa    = item_r.fd;
    map_wd    = '0;
    map_ra    = item_r.fd;
    slot_we   = 1'b0;
    slot_wa   = take_idx;
    slot_wd   = '{fd: item_r.fd, ev: item_r.ev};
    slot_ra   = item_r.sidx;
    stk_we    = 1'b0;
    stk_wa    = fc_r[SW-1:0];
    stk_wd    = item_r.sidx;
    stk_ra    = fc_r[SW-1:0] - SW'(1);

    case (state_r)
      // sweep the descriptor map to invalid after reset
      S_CLR: begin
        map_we  = 1'b1;
        map_wa  = clr_r;
        clr_nxt = clr_r + FW'(1);
        if (clr_r == FW'(csa_pkg::FD_SPACE - 1)) begin
          state_nxt = S_IDLE;
        end
      end

      // take a request and issue the first reads
      S_IDLE: begin
        if (pop_req.valid && !ov_r) begin
          pop_ready = 1'b1;
          item_nxt  = pop_req.cmd;
          map_ra    = pop_req.cmd.fd;
          slot_ra   = pop_req.cmd.sidx;
          state_nxt = S_A;
        end
      end

      // first read data available
      S_A: begin
        state_nxt = S_IDLE;
        ov_nxt    = 1'b1;
        st_nxt    = csa_pkg::ST_NONE;
        so_nxt    = '0;
        eo_nxt    = '0;
        case (item_r.op)
          csa_pkg::OP_RECYCLE: begin
            if (({1'b0, item_r.sidx} >= hw_r) || !live_r[item_r.sidx]) begin
              st_nxt = csa_pkg::ST_BAD;
              so_nxt = item_r.sidx;
            end else begin
              map_ra    = slot_rd_r.fd;
              ov_nxt    = 1'b0;
              state_nxt = S_B;
            end
          end
          csa_pkg::OP_ACQUIRE: begin
            if (take_ok) begin
              if (fc_r != '0) fc_nxt = fc_r - CW'(1);
              else            hw_nxt = hw_r + CW'(1);
              slot_we            = 1'b1;
              live_nxt[take_idx] = 1'b1;
              map_we             = 1'b1;
              map_wd             = '{ov: 1'b1, oi: take_idx, pv: ent.pv, pe: ent.pe};
              st_nxt             = csa_pkg::ST_DONE;
              so_nxt             = take_idx;
              eo_nxt             = item_r.ev;
            end else begin
              st_nxt = csa_pkg::ST_FULL;
            end
          end
          csa_pkg::OP_PARK: begin
            if (ent.ov) begin
              slot_ra   = ent.oi;
              ov_nxt    = 1'b0;
              state_nxt = S_B;
            end
          end
          csa_pkg::OP_RESUME: begin
            if (ent.pv && ent.ov) begin
              slot_we            = 1'b1;
              slot_wa            = ent.oi;
              slot_wd            = '{fd: item_r.fd, ev: ent.pe};
              live_nxt[ent.oi]   = 1'b1;
              map_we             = 1'b1;
              map_wd             = '{ov: 1'b1, oi: ent.oi, pv: 1'b0, pe: ent.pe};
              st_nxt             = csa_pkg::ST_DONE;
              so_nxt             = ent.oi;
              eo_nxt             = ent.pe;
            end else if (ent.pv && take_ok) begin
              if (fc_r != '0) fc_nxt = fc_r - CW'(1);
              else            hw_nxt = hw_r + CW'(1);
              slot_we            = 1'b1;
              slot_wd            = '{fd: item_r.fd, ev: ent.pe};
              live_nxt[take_idx] = 1'b1;
              map_we             = 1'b1;
              map_wd             = '{ov: 1'b1, oi: take_idx, pv: 1'b0, pe: ent.pe};
              st_nxt             = csa_pkg::ST_DONE;
              so_nxt             = take_idx;
              eo_nxt             = ent.pe;
            end else if (ent.pv) begin
              st_nxt = csa_pkg::ST_FULL;
            end
          end
          csa_pkg::OP_RELEASE: begin
            map_we = 1'b1;
            map_wd = '{ov: 1'b0, oi: ent.oi, pv: 1'b0, pe: ent.pe};
            if (!ent.ov) begin
              st_nxt = ent.pv ? csa_pkg::ST_DONE : csa_pkg::ST_NONE;
            end else begin
              if (live_r[ent.oi]) begin
                live_nxt[ent.oi] = 1'b0;
                if (fc_r < CW'(csa_pkg::SLOTS)) begin
                  stk_we = 1'b1;
                  stk_wd = ent.oi;
                  fc_nxt = fc_r + CW'(1);
                end
              end
              st_nxt = csa_pkg::ST_DONE;
              so_nxt = ent.oi;
            end
          end
          default: begin
          end
        endcase
      end

      // second read data available: recycle and park
      S_B: begin
        state_nxt = S_IDLE;
        ov_nxt    = 1'b1;
        st_nxt    = csa_pkg::ST_DONE;
        eo_nxt    = '0;
        case (item_r.op)
          csa_pkg::OP_RECYCLE: begin
            if (ent.ov && (ent.oi == item_r.sidx)) begin
              map_we = 1'b1;
              map_wa = slot_rd_r.fd;
              map_wd = '{ov: 1'b0, oi: ent.oi, pv: ent.pv, pe: ent.pe};
            end
            live_nxt[item_r.sidx] = 1'b0;
            if (fc_r < CW'(csa_pkg::SLOTS)) begin
              stk_we = 1'b1;
              fc_nxt = fc_r + CW'(1);
            end
            so_nxt = item_r.sidx;
          end
          csa_pkg::OP_PARK: begin
            map_we = 1'b1;
            map_wd = '{ov: 1'b0, oi: ent.oi, pv: 1'b1,
                       pe: live_r[ent.oi] ? slot_rd_r.ev : '0};
            if (live_r[ent.oi]) begin
              live_nxt[ent.oi] = 1'b0;
              if (fc_r < CW'(csa_pkg::SLOTS)) begin
                stk_we = 1'b1;
                stk_wd = ent.oi;
                fc_nxt = fc_r + CW'(1);
              end
            end
            so_nxt = ent.oi;
          end
          default: begin
            st_nxt = csa_pkg::ST_NONE;
            so_nxt = '0;
          end
        endcase
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLR;
      clr_r   <= '0;
      hw_r    <= '0;
      fc_r    <= '0;
      live_r  <= '0;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      clr_r   <= clr_nxt;
      hw_r    <= hw_nxt;
      fc_r    <= fc_nxt;
      live_r  <= live_nxt;
      ov_r    <= ov_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    item_r <= item_nxt;
    st_r   <= st_nxt;
    so_r   <= so_nxt;
    eo_r   <= eo_nxt;
  end

  // descriptor map
  always_ff @(posedge clk) begin
    if (map_we) begin
      map_mem[map_wa] <= map_wd;
    end
    map_rd_r <= map_mem[map_ra];
  end

  // slot table
  always_ff @(posedge clk) begin
    if (slot_we) begin
      slot_mem[slot_wa] <= slot_wd;
    end
    slot_rd_r <= slot_mem[slot_ra];
  end

  // free stack
  always_ff @(posedge clk) begin
    if (stk_we) begin
      stk_mem[stk_wa] <= stk_wd;
    end
    stk_rd_r <= stk_mem[stk_ra];
  end

endmodule

`default_nettype wire
